// ===== hdl/pcmc_pkg.sv =====
// Shared constants, register codes and scaling helper for the pot-to-CC block.
`timescale 1ns / 1ps

package pcmc_pkg;

  // Field widths
  localparam int POT_W     = 4;
  localparam int SAMPLE_W  = 10;
  localparam int TIME_W    = 32;
  localparam int CHAN_W    = 4;
  localparam int CC_W      = 7;
  localparam int TIMEOUT_W = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Number of pots tracked by default
  localparam int NUM_POTS_DEFAULT = 16;

  // Register reset values
  localparam logic [SAMPLE_W-1:0]  THRESHOLD_RST = SAMPLE_W'(16);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = TIMEOUT_W'(300);
  localparam logic [CHAN_W-1:0]    CHANNEL_RST   = '0;
  localparam logic [CC_W-1:0]      CC_BASE_RST   = '0;

  // Full-scale values for the sample*127/1023 mapping
  localparam int SAMPLE_MAX = 1023;
  localparam int CC_MAX     = 127;

  // Register index codes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_CHANNEL   = 2'd2,
    REG_CC_BASE   = 2'd3
  } cfg_reg_t;

  // Scale a raw reading to 0..127, truncating: floor(raw * 127 / 1023).
  // Since 1023 = 1024 - 1, take prod >> 10 as first guess; the remainder
  // (prod mod 1024) + guess stays below 2 * 1023, so one correction step.
  function automatic logic [CC_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W+CC_W-1:0] prod;
    logic [CC_W-1:0]          guess;
    logic [SAMPLE_W:0]        rem;
    prod  = ({CC_W'(0), raw} << CC_W) - {CC_W'(0), raw};
    guess = prod[SAMPLE_W+CC_W-1:SAMPLE_W];
    rem   = {1'b0, prod[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(guess);
    if (rem >= (SAMPLE_W+1)'(SAMPLE_MAX)) begin
      scale_sample = guess + CC_W'(1);
    end else begin
      scale_sample = guess;
    end
  endfunction

endpackage

// ===== hdl/pot_change_to_midi_cc_core.sv =====
// Potentiometer change detector producing MIDI control-change results.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   reading | pot_valid/pot_stall, pot_index,  | in
//           | sample, now_ms                   |
//   result  | cc_valid/cc_stall, channel,      | out
//           | controller, value                |
//   config  | cfg_we, cfg_index, cfg_data      | in
//
// A reading lands in the input register, then one pass of logic updates the
// per-pot state and loads the result register: one reading per cycle while
// the result register is not stalled.
// Reset (rst, synchronous) clears all per-pot state, the config registers and the valid flags.
// A stalled result holds the result register; the input register keeps
// taking a reading while it is empty.
`timescale 1ns / 1ps

module pot_change_to_midi_cc_core #(
  parameter int NUM_POTS = pcmc_pkg::NUM_POTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [pcmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcmc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // readings
  input  logic                           pot_valid,
  output logic                           pot_stall,
  input  logic [pcmc_pkg::POT_W-1:0]     pot_index,
  input  logic [pcmc_pkg::SAMPLE_W-1:0]  sample,
  input  logic [pcmc_pkg::TIME_W-1:0]    now_ms,
  // control-change results
  output logic                           cc_valid,
  input  logic                           cc_stall,
  output logic [pcmc_pkg::CHAN_W-1:0]    channel,
  output logic [pcmc_pkg::CC_W-1:0]      controller,
  output logic [pcmc_pkg::CC_W-1:0]      value
);

  import pcmc_pkg::*;

  // Only pots reachable by the index field need storage
  localparam int DEPTH = (NUM_POTS < (1 << POT_W)) ? NUM_POTS : (1 << POT_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [SAMPLE_W-1:0]  threshold;
  logic [TIMEOUT_W-1:0] timeout;
  logic [CHAN_W-1:0]    midi_channel;
  logic [CC_W-1:0]      cc_base;

  // Per-pot state
  logic [SAMPLE_W-1:0] accepted_raw [DEPTH];
  logic [CC_W-1:0]     sent_value   [DEPTH];
  logic [TIME_W-1:0]   active_time  [DEPTH];

  // Input register
  logic                s1_valid;
  logic [POT_W-1:0]    s1_pot;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [TIME_W-1:0]   s1_now;

  // Processing signals
  logic                s1_adv;
  logic                pot_ok;
  logic [IDX_W-1:0]    idx;
  logic [SAMPLE_W-1:0] old_raw;
  logic [CC_W-1:0]     old_sent;
  logic [TIME_W-1:0]   old_active;
  logic [CC_W-1:0]     scaled;
  logic [SAMPLE_W-1:0] diff;
  logic                active_hit;
  logic [TIME_W-1:0]   elapsed;
  logic                moving;
  logic                fire;
  logic                update;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      timeout      <= TIMEOUT_RST;
      midi_channel <= CHANNEL_RST;
      cc_base      <= CC_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: threshold    <= cfg_data[SAMPLE_W-1:0];
        REG_TIMEOUT:   timeout      <= cfg_data[TIMEOUT_W-1:0];
        REG_CHANNEL:   midi_channel <= cfg_data[CHAN_W-1:0];
        REG_CC_BASE:   cc_base      <= cfg_data[CC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register advances when the result register is free or draining
  assign s1_adv    = !cc_valid || !cc_stall;
  assign pot_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!pot_stall) begin
      s1_valid <= pot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pot_valid && !pot_stall) begin
      s1_pot    <= pot_index;
      s1_sample <= sample;
      s1_now    <= now_ms;
    end
  end

  // Read the pot's state and decide
  assign pot_ok     = (32'(s1_pot) < NUM_POTS);
  assign idx        = IDX_W'(s1_pot);
  assign old_raw    = accepted_raw[idx];
  assign old_sent   = sent_value[idx];
  assign old_active = active_time[idx];
  assign scaled     = scale_sample(s1_sample);

  always_comb begin
    if (s1_sample >= old_raw) begin
      diff = s1_sample - old_raw;
    end else begin
      diff = old_raw - s1_sample;
    end
  end

  // A fresh activity mark makes elapsed time zero
  assign active_hit = (diff > threshold);
  assign elapsed    = active_hit ? '0 : (s1_now - old_active);
  assign moving     = (elapsed < {{(TIME_W-TIMEOUT_W){1'b0}}, timeout});
  assign update     = s1_valid && s1_adv && pot_ok;
  assign fire       = moving && (scaled != old_sent);

  // Write back per-pot state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        accepted_raw[k] <= '0;
        sent_value[k]   <= '0;
        active_time[k]  <= '0;
      end
    end else if (update) begin
      if (active_hit) begin
        active_time[idx] <= s1_now;
      end
      if (fire) begin
        accepted_raw[idx] <= s1_sample;
        sent_value[idx]   <= scaled;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cc_valid <= 1'b0;
    end else if (s1_adv) begin
      cc_valid <= update && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (update && fire) begin
      channel    <= midi_channel;
      controller <= cc_base + CC_W'(s1_pot);
      value      <= scaled;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the pot-to-CC core: CC tracker class, drivers and run control.
`timescale 1ns / 1ps

module tb_top;
  import pcmc_pkg::*;

  localparam int NUM_POTS    = 16;
  localparam int SETTLE      = 8;       // enough for the input and result registers to drain
  localparam int LONG_HOLD   = 300;     // receiver hold-off while readings keep coming
  localparam int CYCLE_LIMIT = 400000;

  // One control-change message
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [CC_W-1:0]   ctl;
    logic [CC_W-1:0]   val;
  } cc_msg_t;

  // Per-pot change tracker: mirrors the registers and pot state, queues the CC messages due
  class cc_tracker;
    logic [SAMPLE_W-1:0]  threshold;
    logic [TIMEOUT_W-1:0] window_ms;
    logic [CHAN_W-1:0]    chan;
    logic [CC_W-1:0]      base;
    logic [SAMPLE_W-1:0]  last_raw[NUM_POTS];
    logic [CC_W-1:0]      last_sent[NUM_POTS];
    logic [TIME_W-1:0]    active_at[NUM_POTS];
    cc_msg_t              pending_cc[$];
    int                   mismatches;
    int                   checked;

    function new();
      threshold  = THRESHOLD_RST;
      window_ms  = TIMEOUT_RST;
      chan       = CHANNEL_RST;
      base       = CC_BASE_RST;
      mismatches = 0;
      checked    = 0;
      for (int k = 0; k < NUM_POTS; k++) begin
        last_raw[k]  = '0;
        last_sent[k] = '0;
        active_at[k] = '0;
      end
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
      case (r)
        REG_THRESHOLD: threshold = d[SAMPLE_W-1:0];
        REG_TIMEOUT:   window_ms = d[TIMEOUT_W-1:0];
        REG_CHANNEL:   chan      = d[CHAN_W-1:0];
        REG_CC_BASE:   base      = d[CC_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted reading; queue a CC when the pot is moving and its value changed
    function void note_reading(logic [POT_W-1:0] p, logic [SAMPLE_W-1:0] s,
                               logic [TIME_W-1:0] t);
      int unsigned       scaled;
      int unsigned       delta;
      logic [TIME_W-1:0] since;
      logic [CC_W-1:0]   cc_val;
      logic [CC_W-1:0]   ctl;
      if (int'(p) >= NUM_POTS) return;
      scaled = (int'(s) * CC_MAX) / SAMPLE_MAX;
      cc_val = scaled[CC_W-1:0];
      delta  = (s >= last_raw[p]) ? int'(s) - int'(last_raw[p])
                                  : int'(last_raw[p]) - int'(s);
      if (delta > threshold) active_at[p] = t;
      since = t - active_at[p];
      if (since < {16'b0, window_ms} && cc_val != last_sent[p]) begin
        last_raw[p]  = s;
        last_sent[p] = cc_val;
        ctl          = base + p;   // wraps modulo 128
        pending_cc.push_back('{chan: chan, ctl: ctl, val: cc_val});
      end
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    // Compare one CC transfer against the oldest queued message
    function void check_cc(logic [CHAN_W-1:0] ch, logic [CC_W-1:0] ctl,
                           logic [CC_W-1:0] val);
      cc_msg_t want;
      checked++;
      if (pending_cc.size() == 0) begin
        note_mismatch($sformatf("unexpected cc ch=%0d ctl=%0d val=%0d", ch, ctl, val));
        return;
      end
      want = pending_cc.pop_front();
      if (want.chan !== ch || want.ctl !== ctl || want.val !== val)
        note_mismatch($sformatf("cc expected ch=%0d ctl=%0d val=%0d, got ch=%0d ctl=%0d val=%0d",
                                want.chan, want.ctl, want.val, ch, ctl, val));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    pot_valid;
  logic                    pot_stall;
  logic [POT_W-1:0]        pot_index;
  logic [SAMPLE_W-1:0]     sample;
  logic [TIME_W-1:0]       now_ms;
  logic                    cc_valid;
  logic                    cc_stall;
  logic [CHAN_W-1:0]       channel;
  logic [CC_W-1:0]         controller;
  logic [CC_W-1:0]         value;

  cc_tracker         tracker = new();
  logic [TIME_W-1:0] clock_ms = '0;
  int                walk[NUM_POTS];
  int                readings_sent = 0;
  int                input_stalls = 0;
  int                settings_used = 0;
  int                cycles = 0;
  bit                tx_idle_on = 1'b0;
  bit                rx_idle_on = 1'b0;
  bit                quiet = 1'b0;
  bit                long_hold_req = 1'b0;

  pot_change_to_midi_cc_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pot_valid  (pot_valid),
    .pot_stall  (pot_stall),
    .pot_index  (pot_index),
    .sample     (sample),
    .now_ms     (now_ms),
    .cc_valid   (cc_valid),
    .cc_stall   (cc_stall),
    .channel    (channel),
    .controller (controller),
    .value      (value)
  );

  always #6 clk = ~clk;

  // Offer one reading and hold it until the transfer; maybe idle afterward
  task automatic send_reading(input logic [POT_W-1:0] p, input logic [SAMPLE_W-1:0] s,
                              input logic [TIME_W-1:0] t);
    pot_valid <= 1'b1;
    pot_index <= p;
    sample    <= s;
    now_ms    <= t;
    @(posedge clk);
    while (pot_stall) begin
      input_stalls++;
      @(posedge clk);
    end
    tracker.note_reading(p, s, t);
    readings_sent++;
    if (tx_idle_on && !quiet && $urandom_range(0, 7) == 0) begin
      pot_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    tracker.set_reg(r, d);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] th, win, ch, cc0);
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_TIMEOUT, win);
    write_reg(REG_CHANNEL, ch);
    write_reg(REG_CC_BASE, cc0);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Drain all queued CCs, then let any reading that made no CC clear the pipe
  task automatic wait_idle();
    pot_valid <= 1'b0;
    while (tracker.pending_cc.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly knob turns on one pot at a time; some noise readings with time jumps
  task automatic run_moves(input int n);
    int               left;
    int               len;
    int               span;
    logic [POT_W-1:0] p;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        clock_ms = clock_ms + $urandom;
        send_reading(POT_W'($urandom_range(0, 15)), SAMPLE_W'($urandom_range(0, 1023)),
                     clock_ms);
        left--;
      end else begin
        p   = POT_W'($urandom_range(0, 15));
        len = $urandom_range(2, 8);
        for (int k = 0; k < len && left > 0; k++) begin
          clock_ms = clock_ms + $urandom_range(0, 20);
          span = ($urandom_range(0, 3) == 0) ? 300 : 40;
          walk[p] = walk[p] + int'($urandom_range(0, 2 * span)) - span;
          if ($urandom_range(0, 15) == 0) walk[p] = ($urandom_range(0, 1) == 0) ? 0 : 1023;
          if (walk[p] < 0) walk[p] = 0;
          if (walk[p] > 1023) walk[p] = 1023;
          send_reading(p, SAMPLE_W'(walk[p]), clock_ms);
          left--;
        end
      end
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    cc_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        cc_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        cc_stall <= 1'b0;
      end else if (rx_idle_on && !quiet && $urandom_range(0, 7) == 0) begin
        cc_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        cc_stall <= 1'b0;
      end
    end
  end

  // Check every CC transfer
  always @(posedge clk) begin
    if (!rst && cc_valid && !cc_stall) tracker.check_cc(channel, controller, value);
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pot_change_to_midi_cc_core regression: fail");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    pot_valid <= 1'b0;
    pot_index <= '0;
    sample    <= '0;
    now_ms    <= '0;
    for (int k = 0; k < NUM_POTS; k++) walk[k] = 512;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full-scale swings, small change under threshold,
    // timeout edge, alternating bit patterns, timestamp wrap
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_reading(4'd0, 10'd1023, 32'd5);
    send_reading(4'd0, 10'd0, 32'd6);
    send_reading(4'd15, 10'd1023, 32'd10);
    send_reading(4'd1, 10'd8, 32'd12);
    send_reading(4'd2, 10'd9, 32'd20);
    send_reading(4'd3, 10'd500, 32'd1000);
    send_reading(4'd3, 10'd510, 32'd1299);
    send_reading(4'd3, 10'd520, 32'd1310);
    send_reading(4'd5, 10'h2AA, 32'hAAAA_AAAA);
    send_reading(4'd5, 10'h155, 32'h5555_5555);
    send_reading(4'd4, 10'd800, 32'hFFFF_FFF0);
    send_reading(4'd4, 10'd790, 32'h0000_0010);
    clock_ms = 32'h20;
    run_moves(300);
    wait_idle();

    // Zero threshold, longest timeout; hold the receiver so the core backs up
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_config(16'h0000, 16'hFFFF, 16'h000F, 16'd112);
    long_hold_req = 1'b1;
    for (int k = 0; k < 40; k++) begin
      clock_ms = clock_ms + 1;
      send_reading(POT_W'(k), SAMPLE_W'($urandom_range(0, 1023)), clock_ms);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_moves(260);
    wait_idle();

    // Top controller base: controller numbers wrap past 127; upper data bits dropped
    set_config(16'hFC00, 16'hFFFF, 16'hFFF5, 16'hFF7F);
    send_reading(4'd0, 10'd512, clock_ms + 1);
    send_reading(4'd1, 10'd0, clock_ms + 2);
    send_reading(4'd1, 10'd1023, clock_ms + 3);
    send_reading(4'd15, 10'd300, clock_ms + 4);
    send_reading(4'd15, 10'd700, clock_ms + 5);
    clock_ms = clock_ms + 5;
    run_moves(250);
    wait_idle();

    // Highest threshold: no reading can mark a pot active
    set_config(16'hFFFF, 16'd2000, 16'd9, 16'd64);
    run_moves(100);
    wait_idle();

    // Zero timeout: nothing ever counts as moving
    set_config(16'd16, 16'd0, 16'd1, 16'd0);
    send_reading(4'd6, 10'd1023, clock_ms + 1);
    send_reading(4'd6, 10'd0, clock_ms + 2);
    clock_ms = clock_ms + 2;
    run_moves(100);
    wait_idle();

    // Random settings
    repeat (3) begin
      set_config(CFG_DATA_W'($urandom_range(0, 65535)), CFG_DATA_W'($urandom_range(1, 2000)),
                 CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 127)));
      run_moves(150);
      wait_idle();
    end

    // Closing stretch at full rate on both sides
    quiet = 1'b1;
    set_config(16'd16, 16'd300, 16'd3, 16'd40);
    run_moves(300);
    pot_valid <= 1'b0;
    while (tracker.pending_cc.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d readings over %0d register settings; %0d control changes checked.",
             readings_sent, settings_used + 1, tracker.checked);
    $display("Reading input stalled on %0d cycles, including a %0d-cycle result hold-off.",
             input_stalls, LONG_HOLD);
    if (tracker.mismatches == 0) begin
      $display("pot_change_to_midi_cc_core regression: pass");
    end else begin
      $display("%0d mismatches in total", tracker.mismatches);
      $display("pot_change_to_midi_cc_core regression: fail");
    end
    $finish;
  end

endmodule
